@@ sv/assert_macros.svh @@
// Assertion macros used by the top RTL file of the key-value cache.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ sv/lkv_pkg.sv @@
// Shared types and constants of the LRU key-value cache.
package lkv_pkg;

    localparam int LKV_ENTRIES = 16;
    localparam int CAP_W       = 5;
    localparam int DATA_W      = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Register index decoded from paddr[APB_ADDR_W-1:2]
    localparam logic [APB_ADDR_W-3:0] REG_CAPACITY = '0;

    // Operation codes
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_UPDATE,
        ST_RESP
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;    // take the input beat
        logic match;   // register compare and slot choice
        logic update;  // write key, value, ranks
        logic resp;    // load the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

@@ sv/lru_key_value_cache.sv @@
// Fully associative key-value cache with least-recently-used replacement.
// Each slave beat is a get or a put and yields exactly one master beat.
// Each beat goes through these steps in order: the beat is taken, the key is compared
// against all entries in parallel and the target slot registered, keys,
// ranks and the value RAM are updated (the value RAM read is registered),
// then the result moves into the output register once it is free. The next beat is taken
// while a result still waits there; no beat is taken before the previous one has reached
// the output register. Valid bits and ranks clear at reset; no clearing pass.
// Capacity (APB byte address 0) is 0 to mean 1 and saturates at ENTRIES.
`include "assert_macros.svh"

module lru_key_value_cache import lkv_pkg::*; #(
    parameter int ENTRIES = LKV_ENTRIES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,  // [31:0] key, [63:32] write_value
    input  logic                  s_tuser,  // [0] command
    // master stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,  // [31:0] read_value
    output logic [1:0]            m_tuser,  // [0] hit, [1] evicted
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CAP_W-1:0] r_capacity;
    logic             apb_wr;
    logic             reg_cap_sel;
    t_dp_cmd          dp_cmd;
    t_dp_stat         dp_stat;
    logic             in_accept;

    // Capacity register
    assign pready      = 1'b1;
    assign reg_cap_sel = (paddr[APB_ADDR_W-1:2] == REG_CAPACITY);
    assign apb_wr      = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (apb_wr && reg_cap_sel) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = reg_cap_sel ? APB_DATA_W'(r_capacity) : '0;

    assign in_accept = s_tvalid && s_tready;

    lkv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .i_stat     (dp_stat),
        .o_in_ready (s_tready),
        .o_cmd      (dp_cmd)
    );

    lkv_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_capacity    (r_capacity),
        .i_in_cmd      (s_tuser),
        .i_in_key      (s_tdata[31:0]),
        .i_in_val      (s_tdata[63:32]),
        .o_out_valid   (m_tvalid),
        .i_out_ready   (m_tready),
        .o_out_hit     (m_tuser[0]),
        .o_out_value   (m_tdata),
        .o_out_evicted (m_tuser[1])
    );

    // Checks
    `ASSERT_IMPL(a_hit_not_evict, i_clk, i_rst_n, m_tvalid, !(m_tuser[0] && m_tuser[1]))
    `ASSERT_IMPL(a_value_needs_hit, i_clk, i_rst_n, m_tvalid && (m_tdata != '0), m_tuser[0])
    `ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, in_accept, !s_tready)
    `ASSERT_IMPL(a_cmd_onehot, i_clk, i_rst_n, 1'b1, $onehot0(dp_cmd))

endmodule

@@ sv/lkv_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/lkv_ctrl.sv @@
// Sequencing state machine of the key-value cache.
module lkv_ctrl import lkv_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_MATCH;
            end
            ST_MATCH:  n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_RESP;
            ST_RESP: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // Outputs; no beat is taken while reset is held
    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = i_rst_n;
                o_cmd.load = i_in_valid && i_rst_n;
            end
            ST_MATCH:  o_cmd.match  = 1'b1;
            ST_UPDATE: o_cmd.update = 1'b1;
            ST_RESP:   o_cmd.resp   = i_stat.out_free;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ sv/lkv_dp.sv @@
// Datapath of the key-value cache: key lanes, ranks, value RAM, result register.
module lkv_dp import lkv_pkg::*; #(
    parameter int ENTRIES = LKV_ENTRIES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  logic [CAP_W-1:0]  i_capacity,
    input  logic              i_in_cmd,
    input  logic [DATA_W-1:0] i_in_key,
    input  logic [DATA_W-1:0] i_in_val,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_out_hit,
    output logic [DATA_W-1:0] o_out_value,
    output logic              o_out_evicted
);

    localparam int SLOT_W = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int EW     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [EW-1:0] ENTRIES_EW = EW'(ENTRIES);

    // Input beat
    logic              r_cmd;
    logic [DATA_W-1:0] r_key;
    logic [DATA_W-1:0] r_val;

    // Entry lanes
    logic [DATA_W-1:0] r_keys  [ENTRIES];
    logic [SLOT_W-1:0] r_rank  [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [CNT_W-1:0]  r_used;

    // Match results
    logic              r_hit;
    logic              r_insert;
    logic              r_evict;
    logic              r_promote;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] r_slot_rank;

    // Result register
    logic              r_out_valid;
    logic              r_out_hit;
    logic [DATA_W-1:0] r_out_value;
    logic              r_out_evicted;

    logic [ENTRIES-1:0] match_vec;
    logic [SLOT_W-1:0]  match_idx;
    logic [SLOT_W-1:0]  match_rank;
    logic [SLOT_W-1:0]  free_idx;
    logic [SLOT_W-1:0]  lru_idx;
    logic [CNT_W-1:0]   used_m1;
    logic [EW-1:0]      cap_ext;
    logic [EW-1:0]      eff_cap;
    logic               has_room;
    logic               any_hit;
    logic [DATA_W-1:0]  ram_rdata;
    logic               out_free;

    // Input beat capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_in_cmd;
            r_key <= i_in_key;
            r_val <= i_in_val;
        end
    end

    // Effective capacity: zero acts as one, saturate at the entry count
    always_comb begin
        cap_ext = EW'(i_capacity);
        if (cap_ext == '0) begin
            eff_cap = EW'(1);
        end else if (cap_ext > ENTRIES_EW) begin
            eff_cap = ENTRIES_EW;
        end else begin
            eff_cap = cap_ext;
        end
        has_room = EW'(r_used) < eff_cap;
    end

    // Parallel key compare; keys are distinct so a hit is one-hot.
    // The LRU entry is the one ranked used_count-1.
    always_comb begin
        used_m1    = r_used - CNT_W'(1);
        match_vec  = '0;
        match_idx  = '0;
        match_rank = '0;
        lru_idx    = '0;
        free_idx   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match_vec[i] = r_valid[i] && (r_keys[i] == r_key);
            if (match_vec[i]) begin
                match_idx  = match_idx | SLOT_W'(i);
                match_rank = match_rank | r_rank[i];
            end
            if (r_valid[i] && (CNT_W'(r_rank[i]) == used_m1)) begin
                lru_idx = lru_idx | SLOT_W'(i);
            end
        end
        // lowest free slot
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) free_idx = SLOT_W'(i);
        end
        any_hit = |match_vec;
    end

    // Slot decision
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit     <= 1'b0;
            r_insert  <= 1'b0;
            r_evict   <= 1'b0;
            r_promote <= 1'b0;
        end else if (i_cmd.match) begin
            r_hit     <= any_hit;
            r_insert  <= !any_hit && (r_cmd == CMD_PUT) && has_room;
            r_evict   <= !any_hit && (r_cmd == CMD_PUT) && !has_room;
            r_promote <= any_hit || ((r_cmd == CMD_PUT) && !has_room);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.match) begin
            if (any_hit) begin
                r_slot      <= match_idx;
                r_slot_rank <= match_rank;
            end else if (has_room) begin
                r_slot      <= free_idx;
                r_slot_rank <= '0;
            end else begin
                r_slot      <= lru_idx;
                r_slot_rank <= SLOT_W'(used_m1);
            end
        end
    end

    // Key lanes
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (i_cmd.update && (r_insert || r_evict) && (r_slot == SLOT_W'(i))) begin
                r_keys[i] <= r_key;
            end
        end
    end

    // Valid bits, ranks and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_used  <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_cmd.update) begin
            if (r_insert) begin
                r_used <= r_used + CNT_W'(1);
            end
            for (int i = 0; i < ENTRIES; i++) begin
                if ((r_insert || r_promote) && (r_slot == SLOT_W'(i))) begin
                    r_rank[i] <= '0;
                    if (r_insert) r_valid[i] <= 1'b1;
                end else if (r_valid[i] &&
                             (r_insert || (r_promote && (r_rank[i] < r_slot_rank)))) begin
                    r_rank[i] <= r_rank[i] + SLOT_W'(1);
                end
            end
        end
    end

    // Value store
    lkv_ram #(
        .WIDTH (DATA_W),
        .DEPTH (ENTRIES)
    ) u_values (
        .i_clk   (i_clk),
        .i_we    (i_cmd.update && (r_cmd == CMD_PUT)),
        .i_waddr (r_slot),
        .i_wdata (r_val),
        .i_raddr (r_slot),
        .o_rdata (ram_rdata)
    );

    // Result register
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.resp) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.resp) begin
            r_out_hit     <= r_hit;
            r_out_evicted <= r_evict;
            r_out_value   <= (r_hit && (r_cmd == CMD_GET)) ? ram_rdata : '0;
        end
    end

    assign o_stat.out_free = out_free;
    assign o_out_valid     = r_out_valid;
    assign o_out_hit       = r_out_hit;
    assign o_out_value     = r_out_value;
    assign o_out_evicted   = r_out_evicted;

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the LRU key-value cache: directed table, then random phases.
`timescale 1ns / 100ps

module tb_top;
    import lkv_pkg::*;

    // Register index with no register behind it; writes there must be dropped
    localparam logic [APB_ADDR_W-3:0] REG_UNMAPPED = 1'b1;
    localparam logic [APB_ADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};
    localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR = {REG_UNMAPPED, 2'b00};

    localparam int NUM_PHASES  = 10;
    localparam int PHASE_ITEMS = 198;
    localparam int SETTLE_CYCLES = 8;
    localparam int CAP_SWEEP [7] = '{16, 1, 0, 31, 5, 17, 2};

    typedef struct packed {
        logic               hit;
        logic [DATA_W-1:0]  read_value;
        logic               evicted;
    } t_cache_result;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic                   cmd;
        logic [DATA_W-1:0]      key;
        logic [DATA_W-1:0]      data;   // write_value, or pwdata for a register write
        logic [APB_ADDR_W-1:0]  addr;
        logic                   typed;  // want holds a hand-written expectation
        t_cache_result          want;
    } t_stim_row;

    localparam t_cache_result NO_RESULT = '{1'b0, 32'h0, 1'b0};

    // Directed rows: reset capacity, field extremes, hit update, capacity
    // lowered below the fill level, capacity zero, saturation, unmapped write.
    localparam int NUM_ROWS = 24;
    localparam t_stim_row DIRECTED_ROWS [NUM_ROWS] = '{
        '{ROW_ITEM, CMD_GET, 32'h0000_0000, 32'h0000_0000, CAPACITY_ADDR, 1'b1, NO_RESULT},
        '{ROW_ITEM, CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF, CAPACITY_ADDR, 1'b1, NO_RESULT},
        '{ROW_ITEM, CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF, CAPACITY_ADDR, 1'b1,
          '{1'b1, 32'h7FFF_FFFF, 1'b0}},
        '{ROW_ITEM, CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000, CAPACITY_ADDR, 1'b1, NO_RESULT},
        '{ROW_ITEM, CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000, CAPACITY_ADDR, 1'b1, NO_RESULT},
        '{ROW_ITEM, CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF, CAPACITY_ADDR, 1'b1, NO_RESULT},
        '{ROW_ITEM, CMD_PUT, 32'h8000_0000, 32'h1234_5678, CAPACITY_ADDR, 1'b1,
          '{1'b1, 32'h0, 1'b0}},
        '{ROW_ITEM, CMD_GET, 32'h8000_0000, 32'h0000_0000, CAPACITY_ADDR, 1'b1,
          '{1'b1, 32'h1234_5678, 1'b0}},
        '{ROW_ITEM, CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000, CAPACITY_ADDR, 1'b1,
          '{1'b1, 32'h0, 1'b0}},
        '{ROW_ITEM, CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000, CAPACITY_ADDR, 1'b1,
          '{1'b1, 32'h8000_0000, 1'b0}},
        // capacity 2 with four entries held: upper pwdata bits must be ignored
        '{ROW_CFG,  CMD_GET, 32'h0, 32'hFFFF_FFE2, CAPACITY_ADDR, 1'b0, NO_RESULT},
        '{ROW_ITEM, CMD_PUT, 32'h0000_0011, 32'h0000_0001, CAPACITY_ADDR, 1'b1,
          '{1'b0, 32'h0, 1'b1}},
        '{ROW_ITEM, CMD_GET, 32'h0000_0000, 32'h0000_0000, CAPACITY_ADDR, 1'b1, NO_RESULT},
        '{ROW_ITEM, CMD_GET, 32'h0000_0011, 32'h0000_0000, CAPACITY_ADDR, 1'b0, NO_RESULT},
        // capacity zero acts as one
        '{ROW_CFG,  CMD_GET, 32'h0, 32'h0000_0020, CAPACITY_ADDR, 1'b0, NO_RESULT},
        '{ROW_ITEM, CMD_PUT, 32'h0000_0022, 32'h0000_0002, CAPACITY_ADDR, 1'b1,
          '{1'b0, 32'h0, 1'b1}},
        '{ROW_ITEM, CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000, CAPACITY_ADDR, 1'b0, NO_RESULT},
        // capacity 31 saturates at the entry count
        '{ROW_CFG,  CMD_GET, 32'h0, 32'h0000_001F, CAPACITY_ADDR, 1'b0, NO_RESULT},
        '{ROW_ITEM, CMD_PUT, 32'h0000_0033, 32'h0000_0003, CAPACITY_ADDR, 1'b1, NO_RESULT},
        // unmapped register: would set capacity 1 if it were taken
        '{ROW_CFG,  CMD_GET, 32'h0, 32'h0000_0001, UNMAPPED_ADDR, 1'b0, NO_RESULT},
        '{ROW_ITEM, CMD_PUT, 32'h0000_0044, 32'h0000_0004, CAPACITY_ADDR, 1'b1, NO_RESULT},
        '{ROW_ITEM, CMD_PUT, 32'h0000_0055, 32'h0000_0055, CAPACITY_ADDR, 1'b0, NO_RESULT},
        '{ROW_ITEM, CMD_GET, 32'h0000_0022, 32'h0000_0000, CAPACITY_ADDR, 1'b0, NO_RESULT},
        '{ROW_ITEM, CMD_GET, 32'h8000_0000, 32'h0000_0000, CAPACITY_ADDR, 1'b0, NO_RESULT}
    };

    // DUT connections
    logic                   i_clk;
    logic                   i_rst_n  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [63:0]            s_tdata  = '0;  // [31:0] key, [63:32] write_value
    logic                   s_tuser  = CMD_GET;  // [0] command
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [31:0]            m_tdata;    // [31:0] read_value
    logic [1:0]             m_tuser;    // [0] hit, [1] evicted
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr    = '0;
    logic [APB_DATA_W-1:0]  pwdata   = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // Shadow copy of the cache contents
    logic [DATA_W-1:0]  shadow_key   [LKV_ENTRIES];
    logic [DATA_W-1:0]  shadow_value [LKV_ENTRIES];
    bit                 shadow_valid [LKV_ENTRIES];
    int                 shadow_rank  [LKV_ENTRIES];
    int                 shadow_used = 0;
    logic [CAP_W-1:0]   shadow_cap  = CAP_RESET;

    t_cache_result      expected_results [$];
    int                 mismatch_count = 0;
    bit                 gaps_on  = 1'b1;
    bit                 stalls_on = 1'b1;
    int                 ready_hold = 0;

    lru_key_value_cache DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Make a slot most recent; entries that were more recent age by one
    function automatic void make_recent(input int slot);
        int i;
        for (i = 0; i < LKV_ENTRIES; i++)
            if (shadow_valid[i] && i != slot && shadow_rank[i] < shadow_rank[slot])
                shadow_rank[i]++;
        shadow_rank[slot] = 0;
    endfunction

    // Apply one access to the shadow cache and return the result it gives
    function automatic void cache_access(input logic cmd, input logic [DATA_W-1:0] key,
                                         input logic [DATA_W-1:0] value,
                                         output t_cache_result res);
        int i;
        int slot;
        int free_slot;
        int victim;
        int eff_cap;
        slot = -1;
        free_slot = -1;
        victim = -1;
        res = NO_RESULT;
        eff_cap = (shadow_cap == 0) ? 1 : (shadow_cap > LKV_ENTRIES) ? LKV_ENTRIES
                                                                      : int'(shadow_cap);
        for (i = 0; i < LKV_ENTRIES; i++)
            if (slot < 0 && shadow_valid[i] && shadow_key[i] == key)
                slot = i;

        if (slot >= 0) begin
            res.hit = 1'b1;
            if (cmd == CMD_GET)
                res.read_value = shadow_value[slot];
            else
                shadow_value[slot] = value;
            make_recent(slot);
        end else if (cmd == CMD_PUT) begin
            if (shadow_used < eff_cap)
                for (i = 0; i < LKV_ENTRIES; i++)
                    if (free_slot < 0 && !shadow_valid[i])
                        free_slot = i;
            if (free_slot >= 0) begin
                for (i = 0; i < LKV_ENTRIES; i++)
                    if (shadow_valid[i])
                        shadow_rank[i]++;
                shadow_valid[free_slot] = 1'b1;
                shadow_rank[free_slot]  = 0;
                shadow_key[free_slot]   = key;
                shadow_value[free_slot] = value;
                shadow_used++;
            end else if (shadow_used > 0) begin
                // oldest entry: highest rank, first slot on a tie
                for (i = 0; i < LKV_ENTRIES; i++)
                    if (shadow_valid[i] && (victim < 0 || shadow_rank[i] > shadow_rank[victim]))
                        victim = i;
                res.evicted = 1'b1;
                shadow_key[victim]   = key;
                shadow_value[victim] = value;
                make_recent(victim);
            end
        end
    endfunction

    function automatic void flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s", $time, what);
    endfunction

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 24);
    endfunction

    // Present one beat and hold it until taken, then log what it should give
    task automatic send_access(input logic cmd, input logic [DATA_W-1:0] key,
                               input logic [DATA_W-1:0] value, input bit typed,
                               input t_cache_result want);
        t_cache_result predicted;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {value, key};
        do @(posedge i_clk); while (!s_tready);
        cache_access(cmd, key, value, predicted);
        expected_results.push_back(typed ? want : predicted);
    endtask

    task automatic sender_gap();
        int n;
        n = gaps_on ? pick_gap() : 0;
        if (n > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom(), $urandom()};
            s_tuser  <= 1'($urandom_range(0, 1));
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Hold off the sender until every result is back, then let the block settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr[APB_ADDR_W-1:2] == REG_CAPACITY)
            shadow_cap = data[CAP_W-1:0];
    endtask

    // Receiver: ready runs and stalls of random length
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (stalls_on && $urandom_range(0, 3) == 0) begin
            m_tready   <= 1'b0;
            ready_hold <= pick_gap();
        end else begin
            m_tready   <= 1'b1;
            ready_hold <= $urandom_range(0, 6);
        end
    end

    // Result checker: each beat against the oldest expectation
    always @(posedge i_clk) begin
        t_cache_result exp_res;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                flag_mismatch($sformatf("result beat with nothing expected: data %h user %b",
                                        m_tdata, m_tuser));
            end else begin
                exp_res = expected_results.pop_front();
                if (m_tuser[0] !== exp_res.hit)
                    flag_mismatch($sformatf("hit: expected %b, got %b", exp_res.hit,
                                            m_tuser[0]));
                if (m_tdata !== exp_res.read_value)
                    flag_mismatch($sformatf("read_value: expected %h, got %h",
                                            exp_res.read_value, m_tdata));
                if (m_tuser[1] !== exp_res.evicted)
                    flag_mismatch($sformatf("evicted: expected %b, got %b",
                                            exp_res.evicted, m_tuser[1]));
            end
        end
    end

    // Main sequence
    initial begin
        int row;
        int phase;
        int item;
        int cap_pick;
        int eff_cap;
        int pool_size;
        logic [DATA_W-1:0] pick_key;
        logic [DATA_W-1:0] key_pool [$];
        logic [DATA_W-1:0] corner_keys [5];

        corner_keys = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h0000_0001};
        for (row = 0; row < LKV_ENTRIES; row++) begin
            shadow_valid[row] = 1'b0;
            shadow_rank[row]  = 0;
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        for (row = 0; row < NUM_ROWS; row++) begin
            if (DIRECTED_ROWS[row].kind == ROW_CFG) begin
                drain_results();
                reg_write(DIRECTED_ROWS[row].addr, DIRECTED_ROWS[row].data);
            end else begin
                send_access(DIRECTED_ROWS[row].cmd, DIRECTED_ROWS[row].key,
                            DIRECTED_ROWS[row].data, DIRECTED_ROWS[row].typed,
                            DIRECTED_ROWS[row].want);
                sender_gap();
            end
        end

        // Random phases, each with its own capacity, key pool and idling mix
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            drain_results();
            cap_pick = (phase < 7) ? CAP_SWEEP[phase] : $urandom_range(0, 31);
            reg_write(CAPACITY_ADDR, ($urandom() & 32'hFFFF_FFE0) | cap_pick);
            eff_cap = (cap_pick == 0) ? 1 : (cap_pick > LKV_ENTRIES) ? LKV_ENTRIES : cap_pick;
            pool_size = eff_cap + $urandom_range(1, 6);
            key_pool.delete();
            repeat (pool_size)
                key_pool.push_back(($urandom_range(0, 7) == 0) ?
                                   corner_keys[$urandom_range(0, 4)] : $urandom());
            gaps_on   = (phase != 3) && (phase % 3 != 1);
            stalls_on = (phase != 3) && (phase % 3 != 2);

            for (item = 0; item < PHASE_ITEMS; item++) begin
                pick_key = ($urandom_range(0, 9) == 0) ? $urandom() :
                           key_pool[$urandom_range(0, key_pool.size() - 1)];
                send_access(1'($urandom_range(0, 1)), pick_key, $urandom(), 1'b0, NO_RESULT);
                if ($urandom_range(0, 149) == 0)
                    drain_results();
                else
                    sender_gap();
            end
        end

        drain_results();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
